// File: sv/bhpq_pkg.sv
// Shared types and codes for the binary heap priority queue.
`timescale 1ns / 1ps

package bhpq_pkg;

  // Request codes carried in the action field.
  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_POP    = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] key;
    logic [31:0] payload;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_key;
    logic [31:0] out_payload;
    logic [1:0]  status;
    logic [7:0]  entry_count;
    logic        is_empty;
  } out_beat_t;

  // Source of the read address.
  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_ROOT   = 3'd1,
    RD_LAST   = 3'd2,
    RD_PARENT = 3'd3,
    RD_LCHILD = 3'd4,
    RD_RCHILD = 3'd5
  } rd_sel_t;

  // Data written at the current position.
  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_NEW    = 3'd1,
    WR_RDATA  = 3'd2,
    WR_BEST   = 3'd3,
    WR_MOVING = 3'd4
  } wr_sel_t;

  // Update of the position register.
  typedef enum logic [2:0] {
    POS_HOLD   = 3'd0,
    POS_APPEND = 3'd1,
    POS_ROOT   = 3'd2,
    POS_PARENT = 3'd3,
    POS_BEST   = 3'd4
  } pos_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  typedef enum logic [2:0] {
    RES_HOLD  = 3'd0,
    RES_CLEAR = 3'd1,
    RES_ROOT  = 3'd2,
    RES_FULL  = 3'd3,
    RES_EMPTY = 3'd4
  } res_op_t;

  typedef enum logic [1:0] {
    BEST_HOLD  = 2'd0,
    BEST_LEFT  = 2'd1,
    BEST_RIGHT = 2'd2
  } best_op_t;

  // Controller to datapath.
  typedef struct packed {
    logic     load_item;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    pos_sel_t pos_sel;
    cnt_op_t  cnt_op;
    res_op_t  res_op;
    best_op_t best_op;
    logic     load_moving;
    logic     load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
    logic new_wins;
    logic parent_is_root;
    logic lchild_past_end;
    logic rchild_present;
    logic best_wins;
    logic best_lchild_past_end;
  } dp_stat_t;

endpackage

// File: sv/binary_heap_priority_queue_core.sv
// Top level of the binary heap priority queue: controller plus datapath.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Beat contents
//  in        input      in_valid / in_stall   action, key, payload
//  out       output     out_valid / out_stall out_key, out_payload, status,
//                                             entry_count, is_empty
//  cfg       input      cfg_we                order_mode in cfg_wdata
//
//  One request is worked on at a time. An insert compares the new entry with
//  its parent once per level that it climbs, moving the parent down each time.
//  A pop reads the root and then the last entry, and per level reads the left
//  child, the right child where one exists, and compares the best child with
//  the sinking entry. A dropped insert or an empty pop only sets its status.
//  The single heap memory port, one read and one write per cycle, sets the pace.
//  Reset is synchronous and clears the entry count, the ordering mode (to
//  smaller key first) and the control state; the heap memory keeps whatever
//  it holds, as only written slots are ever read. The input is stalled
//  while reset is high.
//  A finished result sits in the output register while the next request is
//  taken; a request reaching its end with that register still stalled waits.

module binary_heap_priority_queue_core import bhpq_pkg::*; #(
  parameter int DEPTH         = 256,
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // Commands flow from the state machine to the datapath, and compare and
  // bound flags flow back; there is no other coupling between the two.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The state machine owns both handshakes. The input side is open only in
  // the idle state, and the output valid flag lives there as well so that a
  // result beat is held steady until the downstream side takes it.
  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the heap memory (entries at slots 1 to DEPTH-1), the
  // entry count, the walk position, the entry being sifted, the best child
  // seen so far, and the output register. Keys and payloads are cut to their
  // configured widths on the way in and zero-extended on the way out.
  bhpq_datapath #(
    .DEPTH         (DEPTH),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// File: sv/bhpq_datapath.sv
// Heap storage, entry count, position and compare logic of the priority queue.
`timescale 1ns / 1ps

module bhpq_datapath import bhpq_pkg::*; #(
  parameter int DEPTH         = 256,
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  in_beat_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_beat_t out_data
);

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CHILD_W = ADDR_W + 1;
  localparam int ENTRY_W = KEY_WIDTH + PAYLOAD_WIDTH;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic                     order_mode;
  logic [ADDR_W-1:0]        count;
  logic [ADDR_W-1:0]        pos;
  logic [ADDR_W-1:0]        pos_next;
  logic                     item_pop;
  logic [KEY_WIDTH-1:0]     item_key;
  logic [PAYLOAD_WIDTH-1:0] item_payload;
  logic [ENTRY_W-1:0]       moving;
  logic [ENTRY_W-1:0]       best;
  logic [ADDR_W-1:0]        best_idx;
  logic [KEY_WIDTH-1:0]     res_key;
  logic [PAYLOAD_WIDTH-1:0] res_payload;
  logic [1:0]               res_status;

  logic [KEY_WIDTH-1:0] rd_key;
  logic [KEY_WIDTH-1:0] best_key;
  logic [KEY_WIDTH-1:0] moving_key;
  logic [CHILD_W-1:0]   n_ext;
  logic [CHILD_W-1:0]   lchild;
  logic [CHILD_W-1:0]   rchild;
  logic [CHILD_W-1:0]   best_lchild;
  logic [CHILD_W-1:0]   next_lchild;
  logic [CHILD_W-1:0]   next_rchild;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_en;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 wr_en;
  logic                 right_wins;

  // True when key a is served strictly before key b.
  function automatic logic outranks(input logic mode, input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b);
    return mode ? (a < b) : (a > b);
  endfunction

  assign rd_key     = rd_data[ENTRY_W-1 -: KEY_WIDTH];
  assign best_key   = best[ENTRY_W-1 -: KEY_WIDTH];
  assign moving_key = moving[ENTRY_W-1 -: KEY_WIDTH];

  assign n_ext       = {1'b0, count};
  assign lchild      = {pos, 1'b0};
  assign rchild      = {pos, 1'b1};
  assign best_lchild = {best_idx, 1'b0};
  assign right_wins  = outranks(order_mode, rd_key, best_key);

  always_comb begin
    unique case (cmd.pos_sel)
      POS_HOLD:   pos_next = pos;
      POS_APPEND: pos_next = count + ADDR_W'(1);
      POS_ROOT:   pos_next = ADDR_W'(1);
      POS_PARENT: pos_next = pos >> 1;
      POS_BEST:   pos_next = best_idx;
      default:    pos_next = pos;
    endcase
  end

  assign next_lchild = {pos_next, 1'b0};
  assign next_rchild = {pos_next, 1'b1};

  always_comb begin
    rd_en = 1'b1;
    unique case (cmd.rd_sel)
      RD_ROOT:   rd_addr = ADDR_W'(1);
      RD_LAST:   rd_addr = count;
      RD_PARENT: rd_addr = pos_next >> 1;
      RD_LCHILD: rd_addr = next_lchild[ADDR_W-1:0];
      RD_RCHILD: rd_addr = next_rchild[ADDR_W-1:0];
      default: begin
        rd_en   = 1'b0;
        rd_addr = pos;
      end
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    unique case (cmd.wr_sel)
      WR_NEW:    wr_data = {item_key, item_payload};
      WR_RDATA:  wr_data = rd_data;
      WR_BEST:   wr_data = best;
      WR_MOVING: wr_data = moving;
      default: begin
        wr_en   = 1'b0;
        wr_data = moving;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b1;
      count      <= '0;
    end else begin
      if (cfg_we) begin
        order_mode <= cfg_wdata;
      end
      unique case (cmd.cnt_op)
        CNT_INC: count <= count + ADDR_W'(1);
        CNT_DEC: count <= count - ADDR_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (cmd.load_item) begin
      item_pop     <= (in_data.action == ACTION_POP);
      item_key     <= in_data.key[KEY_WIDTH-1:0];
      item_payload <= in_data.payload[PAYLOAD_WIDTH-1:0];
    end
    if (cmd.load_moving) begin
      moving <= rd_data;
    end
    unique case (cmd.best_op)
      BEST_LEFT: begin
        best     <= rd_data;
        best_idx <= lchild[ADDR_W-1:0];
      end
      BEST_RIGHT: begin
        if (right_wins) begin
          best     <= rd_data;
          best_idx <= rchild[ADDR_W-1:0];
        end
      end
      default: ;
    endcase
    unique case (cmd.res_op)
      RES_CLEAR: begin
        res_key     <= '0;
        res_payload <= '0;
        res_status  <= STATUS_OK;
      end
      RES_ROOT: begin
        res_key     <= rd_data[ENTRY_W-1 -: KEY_WIDTH];
        res_payload <= rd_data[PAYLOAD_WIDTH-1:0];
        res_status  <= STATUS_OK;
      end
      RES_FULL: begin
        res_key     <= '0;
        res_payload <= '0;
        res_status  <= STATUS_FULL;
      end
      RES_EMPTY: begin
        res_key     <= '0;
        res_payload <= '0;
        res_status  <= STATUS_EMPTY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.out_key     <= 32'(res_key);
      out_data.out_payload <= 32'(res_payload);
      out_data.status      <= res_status;
      out_data.entry_count <= 8'(count);
      out_data.is_empty    <= (count == '0);
    end
  end

  always_comb begin
    stat.is_pop               = item_pop;
    stat.empty                = (count == '0);
    stat.full                 = (count >= ADDR_W'(DEPTH - 1));
    stat.new_wins             = outranks(order_mode, item_key, rd_key);
    stat.parent_is_root       = ((pos >> 1) == ADDR_W'(1));
    stat.lchild_past_end      = (lchild > n_ext);
    stat.rchild_present       = (rchild <= n_ext);
    stat.best_wins            = outranks(order_mode, best_key, moving_key);
    stat.best_lchild_past_end = (best_lchild > n_ext);
  end

endmodule

// File: sv/bhpq_ctrl.sv
// Sequencing state machine for the priority queue insert and pop walks.
`timescale 1ns / 1ps

module bhpq_ctrl import bhpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_START     = 11'b000_0000_0010,
    S_INS_CMP   = 11'b000_0000_0100,
    S_INS_PUT   = 11'b000_0000_1000,
    S_POP_ROOT  = 11'b000_0001_0000,
    S_POP_LAST  = 11'b000_0010_0000,
    S_POP_LEFT  = 11'b000_0100_0000,
    S_POP_RIGHT = 11'b000_1000_0000,
    S_POP_CMP   = 11'b001_0000_0000,
    S_POP_PUT   = 11'b010_0000_0000,
    S_FINISH    = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_START;
        end
      end
      S_START: begin
        if (!stat.is_pop) begin
          if (stat.full) begin
            cmd.res_op = RES_FULL;
            state_next = S_FINISH;
          end else begin
            cmd.res_op  = RES_CLEAR;
            cmd.pos_sel = POS_APPEND;
            if (stat.empty) begin
              state_next = S_INS_PUT;
            end else begin
              cmd.rd_sel = RD_PARENT;
              state_next = S_INS_CMP;
            end
          end
        end else if (stat.empty) begin
          cmd.res_op = RES_EMPTY;
          state_next = S_FINISH;
        end else begin
          cmd.pos_sel = POS_ROOT;
          cmd.rd_sel  = RD_ROOT;
          state_next  = S_POP_ROOT;
        end
      end
      S_INS_CMP: begin
        if (stat.new_wins) begin
          cmd.wr_sel  = WR_RDATA;
          cmd.pos_sel = POS_PARENT;
          if (stat.parent_is_root) begin
            state_next = S_INS_PUT;
          end else begin
            cmd.rd_sel = RD_PARENT;
          end
        end else begin
          cmd.wr_sel = WR_NEW;
          cmd.cnt_op = CNT_INC;
          state_next = S_FINISH;
        end
      end
      S_INS_PUT: begin
        cmd.wr_sel = WR_NEW;
        cmd.cnt_op = CNT_INC;
        state_next = S_FINISH;
      end
      S_POP_ROOT: begin
        cmd.res_op = RES_ROOT;
        cmd.rd_sel = RD_LAST;
        cmd.cnt_op = CNT_DEC;
        state_next = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.load_moving = 1'b1;
        if (stat.lchild_past_end) begin
          state_next = S_POP_PUT;
        end else begin
          cmd.rd_sel = RD_LCHILD;
          state_next = S_POP_LEFT;
        end
      end
      S_POP_LEFT: begin
        cmd.best_op = BEST_LEFT;
        if (stat.rchild_present) begin
          cmd.rd_sel = RD_RCHILD;
          state_next = S_POP_RIGHT;
        end else begin
          state_next = S_POP_CMP;
        end
      end
      S_POP_RIGHT: begin
        cmd.best_op = BEST_RIGHT;
        state_next  = S_POP_CMP;
      end
      S_POP_CMP: begin
        if (stat.best_wins) begin
          cmd.wr_sel  = WR_BEST;
          cmd.pos_sel = POS_BEST;
          if (stat.best_lchild_past_end) begin
            state_next = S_POP_PUT;
          end else begin
            cmd.rd_sel = RD_LCHILD;
            state_next = S_POP_LEFT;
          end
        end else begin
          state_next = S_POP_PUT;
        end
      end
      S_POP_PUT: begin
        if (!stat.empty) begin
          cmd.wr_sel = WR_MOVING;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
